// ===== sv/rbh_pkg.sv =====
// Shared constants, widths and register codes for the radial brush height block.
package rbh_pkg;

   localparam int CELL_W = 12;
   localparam int CEN_W  = 17;
   localparam int RES_W  = 13;
   localparam int HT_W   = 32;
   localparam int POS_W  = 16;
   localparam int D_W    = 17;
   localparam int SQ_W   = 34;
   localparam int CSR_DW = 32;
   localparam int CSR_IW = 3;

   localparam int DIV_SPS  = 4;
   localparam int SQRT_SPS = 4;

   localparam logic [RES_W-1:0] RES_MIN  = 13'd2;
   localparam logic [RES_W-1:0] RES_TOP  = 13'd8191;
   localparam logic [D_W-1:0]   ONE_Q16  = 17'd65536;
   localparam logic [33:0]      CEIL_ADD = 34'd65535;

   typedef enum logic [CSR_IW-1:0] {
      REG_CENTER_X     = 3'd0,
      REG_CENTER_Z     = 3'd1,
      REG_HARD_RADIUS  = 3'd2,
      REG_SMOOTH_WIDTH = 3'd3,
      REG_STRENGTH     = 3'd4,
      REG_RES_X        = 3'd5,
      REG_RES_Z        = 3'd6
   } csr_idx_type;

endpackage

// ===== sv/rbh_ifs.sv =====
// Request and response channel interfaces of the radial brush height block.
interface rbh_req_if;
   logic               valid;
   logic               ready;
   logic [11:0]        cell_x;
   logic [11:0]        cell_z;
   logic signed [31:0] height;
   modport source (output valid, output cell_x, output cell_z, output height, input ready);
   modport sink (input valid, input cell_x, input cell_z, input height, output ready);
endinterface

interface rbh_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] new_height;
   logic               touched;
   logic               saturated;
   modport source (output valid, output new_height, output touched, output saturated,
                   input ready);
   modport sink (input valid, input new_height, input touched, input saturated,
                 output ready);
endinterface

// ===== sv/rbh_div.sv =====
// Pipelined restoring divider: quotient of (rem_start << QW) / divisor, rem_start < divisor.
module rbh_div
   import rbh_pkg::*;
#(
   parameter int DW  = 13,
   parameter int QW  = 16,
   parameter int SPS = 4
) (
   input  logic          clock,
   input  logic          en,
   input  logic [DW-1:0] rem_start,
   input  logic [DW-1:0] divisor,
   output logic [QW-1:0] quo
);

   localparam int NST = (QW + SPS - 1) / SPS;

   logic [DW-1:0] rem_ff [NST];
   logic [QW-1:0] quo_ff [NST];

   for (genvar s = 0; s < NST; s++) begin : g_st
      logic [DW-1:0] rem_src;
      logic [QW-1:0] quo_src;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      if (s == 0) begin : g_first
         assign rem_src = rem_start;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign quo_src = quo_ff[s-1];
      end

      always_comb begin
         logic [DW:0] t;
         rem_in = rem_src;
         quo_in = quo_src;
         for (int k = 0; k < SPS; k++) begin
            if (s * SPS + k < QW) begin
               t = {rem_in, 1'b0};
               if (t >= {1'b0, divisor}) begin
                  rem_in = DW'(t - {1'b0, divisor});
                  quo_in = {quo_in[QW-2:0], 1'b1};
               end else begin
                  rem_in = t[DW-1:0];
                  quo_in = {quo_in[QW-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in;
            quo_ff[s] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[NST-1];

endmodule

// ===== sv/rbh_sqrt.sv =====
// Pipelined digit-by-digit integer square root, floor(sqrt(rad)).
module rbh_sqrt
   import rbh_pkg::*;
#(
   parameter int RW  = 17,
   parameter int SPS = 4
) (
   input  logic            clock,
   input  logic            en,
   input  logic [2*RW-1:0] rad,
   output logic [RW-1:0]   root
);

   localparam int IW  = 2 * RW;
   localparam int NST = (RW + SPS - 1) / SPS;

   logic [IW-1:0] rad_ff  [NST];
   logic [RW+1:0] rem_ff  [NST];
   logic [RW-1:0] root_ff [NST];

   for (genvar s = 0; s < NST; s++) begin : g_st
      logic [IW-1:0] rad_src;
      logic [RW+1:0] rem_src;
      logic [RW-1:0] root_src;
      logic [IW-1:0] rad_in;
      logic [RW+1:0] rem_in;
      logic [RW-1:0] root_in;

      if (s == 0) begin : g_first
         assign rad_src  = rad;
         assign rem_src  = '0;
         assign root_src = '0;
      end else begin : g_next
         assign rad_src  = rad_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign root_src = root_ff[s-1];
      end

      always_comb begin
         logic [RW+3:0] t;
         logic [RW+3:0] trial;
         rad_in  = rad_src;
         rem_in  = rem_src;
         root_in = root_src;
         for (int k = 0; k < SPS; k++) begin
            if (s * SPS + k < RW) begin
               t     = {rem_in, rad_in[IW-1:IW-2]};
               trial = {2'b00, root_in, 2'b01};
               if (t >= trial) begin
                  rem_in  = (RW+2)'(t - trial);
                  root_in = {root_in[RW-2:0], 1'b1};
               end else begin
                  rem_in  = t[RW+1:0];
                  root_in = {root_in[RW-2:0], 1'b0};
               end
               rad_in = {rad_in[IW-3:0], 2'b00};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[s]  <= rad_in;
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
         end
      end
   end

   assign root = root_ff[NST-1];

endmodule

// ===== sv/radial_brush_height_raise_top.sv =====
// Top level of the radial brush height raise pipeline.
//
// Usage: each request on req_chan carries one height-map cell (cell_x, cell_z,
// height). Exactly one response per request leaves on rsp_chan, in order, with the
// new height, whether the brush touched the cell and whether the sum clipped.
// Brush settings are to be written through csr_we / csr_index / csr_wdata
// only while no request is in flight, which the block does not enforce;
// unknown indexes are ignored. Throughput: one request per cycle while not stalled.
// Depth is set by the 16-step position dividers (4 stages), the 17-step square
// root (5 stages) and the 16-step falloff divider (4 stages), four steps a stage.
// The whole pipeline advances together; req_chan.ready is high whenever the
// output register is empty or being taken.
// When the receiver stalls, the output holds and every stage holds with it;
// nothing is dropped or repeated.
// Reset (synchronous, active high) empties the pipeline and restores the brush
// registers to centre 0.5, radii 0.1, strength 0 and resolution 256.
module radial_brush_height_raise_top
   import rbh_pkg::*;
#(
   parameter int MAX_RES = 4096
) (
   input  logic              clock,
   input  logic              reset,
   rbh_req_if.sink           req_chan,
   rbh_rsp_if.source         rsp_chan,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   localparam logic [RES_W-1:0] RES_CAP =
      (MAX_RES > 8191) ? RES_TOP : RES_W'(MAX_RES);
   localparam int PX_LAT   = (POS_W + DIV_SPS - 1) / DIV_SPS;
   localparam int SQRT_LAT = (D_W + SQRT_SPS - 1) / SQRT_SPS;
   localparam int INF_LAT  = (POS_W + DIV_SPS - 1) / DIV_SPS;
   localparam int S_SQ     = PX_LAT + 2;
   localparam int S_D      = S_SQ + SQRT_LAT;
   localparam int S_RING   = S_D + 1;
   localparam int S_Q      = S_RING + INF_LAT;
   localparam int S_PROD   = S_Q + 1;
   localparam int S_OUT    = S_PROD + 1;

   logic [CEN_W-1:0]       cen_x_ff, cen_z_ff, hard_ff, smooth_ff;
   logic signed [HT_W-1:0] strength_ff;
   logic [RES_W-1:0]       res_x_ff, res_z_ff;

   logic [RES_W-1:0] rx, rz, mx, mz;
   logic [CEN_W:0]   total;
   logic             adv;

   logic                   v_ff [1:S_OUT];
   logic signed [HT_W-1:0] h_ff [1:S_PROD];
   logic                   inbox_ff [2:S_D];
   logic                   touch_ff [S_RING:S_Q];
   logic                   inner_ff [S_RING:S_Q];
   logic                   qtop_ff  [S_RING:S_Q];

   logic [CELL_W-1:0]  cx_ff, cz_ff;
   logic signed [33:0] blo_x_ff, bhi_x_ff, blo_z_ff, bhi_z_ff;
   logic signed [33:0] blo_x_in, bhi_x_in, blo_z_in, bhi_z_in;

   logic [POS_W-1:0]   px, pz;
   logic [32:0]        sqx_ff, sqz_ff;
   logic [SQ_W-1:0]    ssum_ff;
   logic [D_W-1:0]     d_root;
   logic [CEN_W-1:0]   rem_ff;
   logic [CEN_W-1:0]   rem_in;
   logic [POS_W-1:0]   qlow;
   logic signed [49:0] prod_ff;
   logic               touch_p_ff;

   logic signed [HT_W-1:0] out_h_ff;
   logic                   out_touch_ff, out_sat_ff;

   function automatic logic [RES_W-1:0] clamp_res(input logic [RES_W-1:0] r);
      logic [RES_W-1:0] v;
      v = r;
      if (r < RES_MIN) v = RES_MIN;
      else if (r > RES_CAP) v = RES_CAP;
      return v;
   endfunction

   function automatic logic box_ok(input logic signed [33:0] plo,
                                   input logic signed [33:0] phi,
                                   input logic [CELL_W-1:0] cidx,
                                   input logic [RES_W-1:0]  m);
      logic signed [17:0] lo, hi, mm, cc, lo_c, hi_c;
      lo   = 18'(plo >>> 16);
      hi   = 18'((phi + $signed(CEIL_ADD)) >>> 16);
      mm   = $signed({5'b0, m});
      cc   = $signed({6'b0, cidx});
      lo_c = (lo < 0) ? 18'sd0 : ((lo > mm) ? mm : lo);
      hi_c = (hi < 0) ? 18'sd0 : ((hi > mm) ? mm : hi);
      return (cc >= lo_c) && (cc <= hi_c);
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cen_x_ff    <= 17'd32768;
         cen_z_ff    <= 17'd32768;
         hard_ff     <= 17'd6554;
         smooth_ff   <= 17'd6554;
         strength_ff <= '0;
         res_x_ff    <= 13'd256;
         res_z_ff    <= 13'd256;
      end else if (csr_we) begin
         case (csr_index)
            REG_CENTER_X:     cen_x_ff    <= csr_wdata[CEN_W-1:0];
            REG_CENTER_Z:     cen_z_ff    <= csr_wdata[CEN_W-1:0];
            REG_HARD_RADIUS:  hard_ff     <= csr_wdata[CEN_W-1:0];
            REG_SMOOTH_WIDTH: smooth_ff   <= csr_wdata[CEN_W-1:0];
            REG_STRENGTH:     strength_ff <= $signed(csr_wdata[HT_W-1:0]);
            REG_RES_X:        res_x_ff    <= csr_wdata[RES_W-1:0];
            REG_RES_Z:        res_z_ff    <= csr_wdata[RES_W-1:0];
            default: ;
         endcase
      end
   end

   assign rx    = clamp_res(res_x_ff);
   assign rz    = clamp_res(res_z_ff);
   assign mx    = rx - 13'd1;
   assign mz    = rz - 13'd1;
   assign total = {1'b0, hard_ff} + {1'b0, smooth_ff};

   assign adv            = !v_ff[S_OUT] || rsp_chan.ready;
   assign req_chan.ready = adv;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= S_OUT; i++) v_ff[i] <= 1'b0;
      end else if (adv) begin
         v_ff[1] <= req_chan.valid;
         for (int i = 2; i <= S_OUT; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   // bounding box products
   always_comb begin
      logic signed [19:0] dlo_x, dhi_x, dlo_z, dhi_z;
      logic signed [33:0] msx, msz;
      dlo_x    = $signed({3'b0, cen_x_ff}) - $signed({2'b0, total});
      dhi_x    = $signed({3'b0, cen_x_ff}) + $signed({2'b0, total});
      dlo_z    = $signed({3'b0, cen_z_ff}) - $signed({2'b0, total});
      dhi_z    = $signed({3'b0, cen_z_ff}) + $signed({2'b0, total});
      msx      = $signed({21'b0, mx});
      msz      = $signed({21'b0, mz});
      blo_x_in = 34'(dlo_x) * msx;
      bhi_x_in = 34'(dhi_x) * msx;
      blo_z_in = 34'(dlo_z) * msz;
      bhi_z_in = 34'(dhi_z) * msz;
   end

   rbh_div #(.DW(RES_W), .QW(POS_W), .SPS(DIV_SPS)) u_div_x (
      .clock     (clock),
      .en        (adv),
      .rem_start ({1'b0, req_chan.cell_x}),
      .divisor   (rx),
      .quo       (px)
   );

   rbh_div #(.DW(RES_W), .QW(POS_W), .SPS(DIV_SPS)) u_div_z (
      .clock     (clock),
      .en        (adv),
      .rem_start ({1'b0, req_chan.cell_z}),
      .divisor   (rz),
      .quo       (pz)
   );

   rbh_sqrt #(.RW(D_W), .SPS(SQRT_SPS)) u_sqrt (
      .clock (clock),
      .en    (adv),
      .rad   (ssum_ff),
      .root  (d_root)
   );

   always_comb begin
      logic [D_W-1:0] e;
      e      = d_root - hard_ff;
      rem_in = (e >= smooth_ff) ? (e - smooth_ff) : e;
   end

   rbh_div #(.DW(CEN_W), .QW(POS_W), .SPS(DIV_SPS)) u_div_ring (
      .clock     (clock),
      .en        (adv),
      .rem_start (rem_ff),
      .divisor   (smooth_ff),
      .quo       (qlow)
   );

   // datapath stages
   always_ff @(posedge clock) begin
      logic signed [17:0] dx, dz;
      logic signed [35:0] sx, sz;
      logic [D_W-1:0]     e;
      logic [D_W-1:0]     infl;
      logic signed [33:0] addv;
      logic signed [34:0] sum;
      if (adv) begin
         h_ff[1]  <= req_chan.height;
         for (int i = 2; i <= S_PROD; i++) h_ff[i] <= h_ff[i-1];
         cx_ff    <= req_chan.cell_x;
         cz_ff    <= req_chan.cell_z;
         blo_x_ff <= blo_x_in;
         bhi_x_ff <= bhi_x_in;
         blo_z_ff <= blo_z_in;
         bhi_z_ff <= bhi_z_in;

         inbox_ff[2] <= box_ok(blo_x_ff, bhi_x_ff, cx_ff, mx) &&
                        box_ok(blo_z_ff, bhi_z_ff, cz_ff, mz);
         for (int i = 3; i <= S_D; i++) inbox_ff[i] <= inbox_ff[i-1];

         dx     = $signed({1'b0, cen_x_ff}) - $signed({2'b0, px});
         dz     = $signed({1'b0, cen_z_ff}) - $signed({2'b0, pz});
         sx     = dx * dx;
         sz     = dz * dz;
         sqx_ff <= sx[32:0];
         sqz_ff <= sz[32:0];

         ssum_ff <= {1'b0, sqx_ff} + {1'b0, sqz_ff};

         e                = d_root - hard_ff;
         touch_ff[S_RING] <= inbox_ff[S_D] &&
                             ((d_root <= hard_ff) ||
                              ({1'b0, d_root} <= total && smooth_ff != '0));
         inner_ff[S_RING] <= d_root <= hard_ff;
         qtop_ff[S_RING]  <= e >= smooth_ff;
         rem_ff           <= rem_in;
         for (int i = S_RING + 1; i <= S_Q; i++) begin
            touch_ff[i] <= touch_ff[i-1];
            inner_ff[i] <= inner_ff[i-1];
            qtop_ff[i]  <= qtop_ff[i-1];
         end

         infl       = inner_ff[S_Q] ? ONE_Q16 : (ONE_Q16 - {qtop_ff[S_Q], qlow});
         prod_ff    <= 50'(strength_ff) * $signed({33'b0, infl});
         touch_p_ff <= touch_ff[S_Q];

         addv = 34'(prod_ff >>> 16);
         sum  = 35'(h_ff[S_PROD]) + 35'(addv);
         if (!touch_p_ff) begin
            out_h_ff   <= h_ff[S_PROD];
            out_sat_ff <= 1'b0;
         end else if (sum > 35'sh07FFFFFFF) begin
            out_h_ff   <= 32'sh7FFFFFFF;
            out_sat_ff <= 1'b1;
         end else if (sum < -35'sh080000000) begin
            out_h_ff   <= 32'sh80000000;
            out_sat_ff <= 1'b1;
         end else begin
            out_h_ff   <= sum[HT_W-1:0];
            out_sat_ff <= 1'b0;
         end
         out_touch_ff <= touch_p_ff;
      end
   end

   assign rsp_chan.valid      = v_ff[S_OUT];
   assign rsp_chan.new_height = out_h_ff;
   assign rsp_chan.touched    = out_touch_ff;
   assign rsp_chan.saturated  = out_sat_ff;

endmodule
